FILE: rtl/core/sorted_string_permutation_generator_unit_macros.svh
// Assertion macros for the sorted string permutation generator.
// Included by the top level; depends on nothing else.
`ifndef SORTED_STRING_PERMUTATION_GENERATOR_UNIT_MACROS_SVH
`define SORTED_STRING_PERMUTATION_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SSPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");
// Next-cycle implication, disabled while reset is asserted.
`define SSPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");
`else
`define SSPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/sspg_pkg.sv
// Shared types and constants of the sorted string permutation generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package sspg_pkg;

	localparam int CHAR_W      = 8;
	localparam int SRC_W       = 3;
	localparam int CMD_W       = 2;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_NEXT   = 2'd2
	} cmd_e_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_APPEND,
		OP_INIT,
		OP_SCAN_START,
		OP_SCAN_I,
		OP_SCAN_J,
		OP_REV_A,
		OP_REV_B,
		OP_EMIT_PREP,
		OP_EMIT,
		OP_SINGLE
	} dp_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND_I,
		ST_FIND_J,
		ST_REV_A,
		ST_REV_B,
		ST_EMIT,
		ST_ONE_EMPTY,
		ST_ONE_EXH
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   exh;
	} dp_cmd_t;

	typedef struct packed {
		logic started;
		logic done;
		logic len_zero;
		logic len_lt2;
		logic i_hit;
		logic i_none;
		logic j_hit;
		logic rev_more;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/sspg_dpath.sv
// Datapath of the permutation generator: sorted character store, index tuple,
// scan pointers and the output register. Depends on sspg_pkg.
module sspg_dpath #(
	parameter int MAX_LENGTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sspg_pkg::dp_cmd_t                cmd,
	input  logic [sspg_pkg::CHAR_W-1:0]      char_in,
	output sspg_pkg::dp_stat_t               stat,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [sspg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	output logic [sspg_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import sspg_pkg::*;

	localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int EW = (IW > SRC_W) ? IW : SRC_W;

	logic [CHAR_W-1:0] store_q [MAX_LENGTH];
	logic [IW-1:0]     tuple_q [MAX_LENGTH];
	logic [CHAR_W-1:0] ins     [MAX_LENGTH];
	logic [LW-1:0]     len_q;
	logic              started_q;
	logic              done_q;
	logic              dropped_q;
	logic [IW-1:0]     ptr_q;
	logic [IW-1:0]     bptr_q;
	logic [IW-1:0]     piv_q;
	logic [IW-1:0]     pval_q;
	logic [IW-1:0]     cmp_q;
	logic [IW-1:0]     tmp_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [SRC_W-1:0]  out_src_q;
	logic              out_cvalid_q;
	logic              out_last_q;
	logic              out_exh_q;
	logic              out_ovf_q;

	logic [LW-1:0]     len_m1;
	logic [IW-1:0]     last_idx;
	logic [IW-1:0]     rd_addr;
	logic [IW-1:0]     rd_data;
	logic [EW-1:0]     rd_ext;
	logic              full;
	logic              load;

	assign len_m1   = len_q - LW'(1);
	assign last_idx = IW'(len_m1);
	assign full     = (len_q == LW'(MAX_LENGTH));
	assign load     = (cmd.op == OP_EMIT) || (cmd.op == OP_SINGLE);

	// The tuple has a single read port; the address follows the current step.
	always_comb begin
		case (cmd.op)
			OP_SCAN_START: rd_addr = last_idx;
			OP_REV_B:      rd_addr = bptr_q;
			default:       rd_addr = ptr_q;
		endcase
	end

	assign rd_data = tuple_q[rd_addr];
	assign rd_ext  = EW'(rd_data);

	assign stat.started   = started_q;
	assign stat.done      = done_q;
	assign stat.len_zero  = (len_q == '0);
	assign stat.len_lt2   = (len_q <= LW'(1));
	assign stat.i_hit     = (rd_data < cmp_q);
	assign stat.i_none    = !(rd_data < cmp_q) && (ptr_q == '0);
	assign stat.j_hit     = (rd_data > pval_q);
	assign stat.rev_more  = (ptr_q < bptr_q);
	assign stat.emit_last = (ptr_q == last_idx);
	assign stat.out_free  = !out_valid_q || m_axis_tready;

	// Sorted insertion: entries greater than the new byte (signed compare)
	// move up one place, and the new byte lands after any equal ones.
	always_comb begin
		logic              prev_gt;
		logic              cur_gt;
		logic [CHAR_W-1:0] prev_val;
		prev_gt  = 1'b0;
		prev_val = '0;
		for (int p = 0; p < MAX_LENGTH; p++) begin
			cur_gt = (LW'(p) < len_q) && ($signed(store_q[p]) > $signed(char_in));
			if (prev_gt) begin
				ins[p] = prev_val;
			end else if (cur_gt || (LW'(p) == len_q)) begin
				ins[p] = char_in;
			end else begin
				ins[p] = store_q[p];
			end
			prev_gt  = cur_gt;
			prev_val = store_q[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			started_q   <= 1'b0;
			done_q      <= 1'b0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CLEAR: begin
					len_q     <= '0;
					started_q <= 1'b0;
					done_q    <= 1'b0;
					dropped_q <= 1'b0;
				end
				OP_APPEND: begin
					if (full) begin
						dropped_q <= 1'b1;
					end else begin
						len_q <= len_q + LW'(1);
					end
					started_q <= 1'b0;
					done_q    <= 1'b0;
				end
				OP_INIT: begin
					started_q <= 1'b1;
				end
				OP_SINGLE: begin
					if (cmd.exh) begin
						done_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_APPEND && !full) begin
			for (int p = 0; p < MAX_LENGTH; p++) begin
				store_q[p] <= ins[p];
			end
		end

		for (int k = 0; k < MAX_LENGTH; k++) begin
			if (cmd.op == OP_INIT) begin
				tuple_q[k] <= IW'(k);
			end else if (cmd.op == OP_SCAN_J && stat.j_hit) begin
				if (IW'(k) == ptr_q) begin
					tuple_q[k] <= pval_q;
				end else if (IW'(k) == piv_q) begin
					tuple_q[k] <= rd_data;
				end
			end else if (cmd.op == OP_REV_B) begin
				if (IW'(k) == ptr_q) begin
					tuple_q[k] <= rd_data;
				end else if (IW'(k) == bptr_q) begin
					tuple_q[k] <= tmp_q;
				end
			end
		end

		case (cmd.op)
			OP_INIT: begin
				ptr_q <= '0;
			end
			OP_SCAN_START: begin
				cmp_q <= rd_data;
				ptr_q <= last_idx - IW'(1);
			end
			OP_SCAN_I: begin
				if (stat.i_hit) begin
					piv_q  <= ptr_q;
					pval_q <= rd_data;
					ptr_q  <= last_idx;
				end else begin
					cmp_q <= rd_data;
					ptr_q <= ptr_q - IW'(1);
				end
			end
			OP_SCAN_J: begin
				if (stat.j_hit) begin
					ptr_q  <= piv_q + IW'(1);
					bptr_q <= last_idx;
				end else begin
					ptr_q <= ptr_q - IW'(1);
				end
			end
			OP_REV_A: begin
				tmp_q <= rd_data;
			end
			OP_REV_B: begin
				ptr_q  <= ptr_q + IW'(1);
				bptr_q <= bptr_q - IW'(1);
			end
			OP_EMIT_PREP: begin
				ptr_q <= '0;
			end
			OP_EMIT: begin
				ptr_q        <= ptr_q + IW'(1);
				out_char_q   <= store_q[rd_data];
				out_src_q    <= rd_ext[SRC_W-1:0];
				out_cvalid_q <= 1'b1;
				out_last_q   <= stat.emit_last;
				out_exh_q    <= 1'b0;
				out_ovf_q    <= dropped_q;
			end
			OP_SINGLE: begin
				out_char_q   <= '0;
				out_src_q    <= '0;
				out_cvalid_q <= 1'b0;
				out_last_q   <= 1'b1;
				out_exh_q    <= cmd.exh;
				out_ovf_q    <= dropped_q;
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - SRC_W - CHAR_W){1'b0}}, out_src_q, out_char_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_ovf_q, out_exh_q, out_cvalid_q};

endmodule

FILE: rtl/core/sspg_ctrl.sv
// Controller state machine of the permutation generator: decodes commands
// and sequences the successor search and emission. Depends on sspg_pkg.
module sspg_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [sspg_pkg::CMD_W-1:0] s_axis_tuser,
	input  sspg_pkg::dp_stat_t         stat,
	output sspg_pkg::dp_cmd_t          cmd
);
	import sspg_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	cmd_e_t      command;

	assign command = cmd_e_t'(s_axis_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && command == CMD_NEXT) begin
					if (stat.done) begin
						state_d = ST_ONE_EXH;
					end else if (!stat.started) begin
						state_d = stat.len_zero ? ST_ONE_EMPTY : ST_EMIT;
					end else if (stat.len_lt2) begin
						state_d = ST_ONE_EXH;
					end else begin
						state_d = ST_FIND_I;
					end
				end
			end
			ST_FIND_I: begin
				if (stat.i_hit) begin
					state_d = ST_FIND_J;
				end else if (stat.i_none) begin
					state_d = ST_ONE_EXH;
				end
			end
			ST_FIND_J: begin
				if (stat.j_hit) begin
					state_d = ST_REV_A;
				end
			end
			ST_REV_A: begin
				state_d = stat.rev_more ? ST_REV_B : ST_EMIT;
			end
			ST_REV_B: begin
				state_d = ST_REV_A;
			end
			ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_ONE_EMPTY, ST_ONE_EXH: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op        = OP_NONE;
		cmd.exh       = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (command)
						CMD_CLEAR:  cmd.op = OP_CLEAR;
						CMD_APPEND: cmd.op = OP_APPEND;
						CMD_NEXT: begin
							if (stat.done) begin
								cmd.op = OP_NONE;
							end else if (!stat.started) begin
								cmd.op = OP_INIT;
							end else if (!stat.len_lt2) begin
								cmd.op = OP_SCAN_START;
							end
						end
						default: cmd.op = OP_NONE;
					endcase
				end
			end
			ST_FIND_I: cmd.op = OP_SCAN_I;
			ST_FIND_J: cmd.op = OP_SCAN_J;
			ST_REV_A:  cmd.op = stat.rev_more ? OP_REV_A : OP_EMIT_PREP;
			ST_REV_B:  cmd.op = OP_REV_B;
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.op = OP_EMIT;
				end
			end
			ST_ONE_EMPTY: begin
				if (stat.out_free) begin
					cmd.op = OP_SINGLE;
				end
			end
			ST_ONE_EXH: begin
				if (stat.out_free) begin
					cmd.op  = OP_SINGLE;
					cmd.exh = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/sorted_string_permutation_generator_unit.sv
// Top level of the sorted string permutation generator.
// Instantiates sspg_ctrl and sspg_dpath; depends on sspg_pkg and the macro header.
//
// Usage: each input beat carries a command in s_axis_tuser and a byte in
// s_axis_tdata. Clear empties the string; append inserts the byte in signed
// sorted order (dropped and flagged when the store is full). Both end in the
// accepting cycle and produce no output beat, so can be issued back to back.
// A next request yields one output beat per character of the following
// permutation, tlast on the final one; an empty string gives one beat with
// no character, and once all permutations are given each request returns a
// single exhausted beat.
// The first permutation goes to emission straight after acceptance. A later
// one first steps the index tuple: it scans down for the pivot, then for its
// swap partner, reverses the suffix pair by pair (a read step and a write step
// per pair) and closes the reversal, then emits one beat per character. The
// steps run one after another on the single read port of the index tuple
// register file. Input is taken only while no request is in progress. A
// stalled receiver holds the output register and pauses emission; nothing
// is lost.
// Reset clears the string length and the status flags; the stores need no clearing.
`include "sorted_string_permutation_generator_unit_macros.svh"

module sorted_string_permutation_generator_unit #(
	parameter int MAX_LENGTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [7:0] char_in
	input  logic [sspg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [1:0] command
	input  logic [sspg_pkg::CMD_W-1:0]           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [7:0] char_out, [10:8] source_index, [15:11] zero
	output logic [sspg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast,
	// [0] char_valid, [1] exhausted, [2] overflow
	output logic [sspg_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
	import sspg_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     in_beat;
	logic     next_beat;
	logic     dp_load;

	sspg_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.stat          (dp_stat),
		.cmd           (dp_cmd)
	);

	sspg_dpath #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.char_in       (s_axis_tdata),
		.stat          (dp_stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign next_beat = in_beat && (s_axis_tuser == CMD_NEXT);
	assign dp_load   = (dp_cmd.op == OP_EMIT) || (dp_cmd.op == OP_SINGLE);

	// A beat is loaded into the output register only when it is free.
	`SSPG_ASSERT_IMP(a_load_needs_room, clk, arst_n, dp_load, dp_stat.out_free)
	// Every next request produces output, so the block goes busy.
	`SSPG_ASSERT_NXT(a_next_goes_busy, clk, arst_n, next_beat, !s_axis_tready)
	// Clear, append and unused commands finish in the accepting cycle.
	`SSPG_ASSERT_NXT(a_edit_stays_idle, clk, arst_n, in_beat && !next_beat, s_axis_tready)

endmodule

FILE: tb/tb_sorted_string_permutation_generator_unit.sv
// Self-checking testbench for sorted_string_permutation_generator_unit.
// It predicts every output beat from the stream of commands and checks each one in order.
// Depends on sspg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sorted_string_permutation_generator_unit;
	import sspg_pkg::*;

	localparam int MAX_LEN = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [SRC_W-1:0]  src;
		logic              valid;
		logic              last;
		logic              exh;
		logic              ovf;
	} perm_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic [IN_TDATA_W-1:0] in_char = '0;
	logic [CMD_W-1:0]      in_cmd = '0;
	logic                  out_ready = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic [OUT_TDATA_W-1:0] out_data;
	logic                  out_last;
	logic [OUT_TUSER_W-1:0] out_user;

	// Predictor state: the sorted string and the current index tuple.
	logic [CHAR_W-1:0] chars_sorted [MAX_LEN];
	logic [SRC_W-1:0]  perm_idx [MAX_LEN];
	int                chars_len = 0;
	bit                perm_started = 1'b0;
	bit                perm_done = 1'b0;
	bit                append_dropped = 1'b0;

	perm_beat_t expected_beats [$];
	int         mismatch_count = 0;
	int         beat_count = 0;
	int         idle_cycles = 0;
	int         stall_left = 0;
	bit         no_idle = 1'b0;

	sorted_string_permutation_generator_unit #(
		.MAX_LENGTH(MAX_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(in_valid),
		.s_axis_tready(in_ready),
		.s_axis_tdata (in_char),
		.s_axis_tuser (in_cmd),
		.m_axis_tvalid(out_valid),
		.m_axis_tready(out_ready),
		.m_axis_tdata (out_data),
		.m_axis_tlast (out_last),
		.m_axis_tuser (out_user)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 4) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Bytes are biased toward the signed extremes and a small alphabet for duplicates.
	function automatic logic [CHAR_W-1:0] rand_char();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 8'h00;
			1: return 8'h7f;
			2: return 8'h80;
			3: return 8'hff;
			4, 5: return 8'h61 + CHAR_W'($urandom_range(0, 2));
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int perm_count(int n);
		int f;
		f = 1;
		for (int k = 2; k <= n; k++)
			f = f * k;
		return f;
	endfunction

	task automatic push_beat(logic [CHAR_W-1:0] ch, logic [SRC_W-1:0] src, logic valid,
			logic last, logic exh);
		perm_beat_t b;
		b.ch = ch;
		b.src = src;
		b.valid = valid;
		b.last = last;
		b.exh = exh;
		b.ovf = append_dropped;
		expected_beats.push_back(b);
	endtask

	// Steps the index tuple to its lexicographic successor; returns 0 if there is none.
	function automatic bit step_perm();
		int i, j, a, b;
		logic [SRC_W-1:0] t;
		if (chars_len < 2)
			return 1'b0;
		i = chars_len - 1;
		while (i > 0 && perm_idx[i-1] >= perm_idx[i])
			i--;
		if (i == 0)
			return 1'b0;
		j = chars_len - 1;
		while (perm_idx[j] <= perm_idx[i-1])
			j--;
		t = perm_idx[i-1];
		perm_idx[i-1] = perm_idx[j];
		perm_idx[j] = t;
		a = i;
		b = chars_len - 1;
		while (a < b) begin
			t = perm_idx[a];
			perm_idx[a] = perm_idx[b];
			perm_idx[b] = t;
			a++;
			b--;
		end
		return 1'b1;
	endfunction

	task automatic model_accept(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
		int pos;
		bit emit;
		case (cmd)
			CMD_CLEAR: begin
				chars_len = 0;
				perm_started = 1'b0;
				perm_done = 1'b0;
				append_dropped = 1'b0;
			end
			CMD_APPEND: begin
				if (chars_len < MAX_LEN) begin
					pos = chars_len;
					// Equal bytes keep their arrival order.
					while (pos > 0 && $signed(chars_sorted[pos-1]) > $signed(ch)) begin
						chars_sorted[pos] = chars_sorted[pos-1];
						pos--;
					end
					chars_sorted[pos] = ch;
					chars_len++;
				end else begin
					append_dropped = 1'b1;
				end
				perm_started = 1'b0;
				perm_done = 1'b0;
			end
			CMD_NEXT: begin
				if (perm_done) begin
					push_beat('0, '0, 1'b0, 1'b1, 1'b1);
				end else begin
					emit = 1'b1;
					if (!perm_started) begin
						perm_started = 1'b1;
						for (int k = 0; k < chars_len; k++)
							perm_idx[k] = SRC_W'(k);
					end else if (!step_perm()) begin
						perm_done = 1'b1;
						push_beat('0, '0, 1'b0, 1'b1, 1'b1);
						emit = 1'b0;
					end
					if (emit && chars_len == 0)
						push_beat('0, '0, 1'b0, 1'b1, 1'b0);
					else if (emit)
						for (int k = 0; k < chars_len; k++)
							push_beat(chars_sorted[perm_idx[k]], perm_idx[k], 1'b1,
								k == chars_len - 1, 1'b0);
				end
			end
			default: ;
		endcase
	endtask

	// Drives one input beat from a falling edge and returns at the edge that accepts it.
	// Valid stays high afterwards; a gap in the next call or a pause lowers it.
	task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
		int gap;
		gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_cmd <= cmd;
		in_char <= ch;
		do
			@(posedge clk);
		while (!in_ready);
		model_accept(cmd, ch);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_beats.size() == 0);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("ERROR beat %0d %s: got 0x%0h, expected 0x%0h", beat_count, what, got,
				want);
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	task automatic check_beat();
		perm_beat_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch("unexpected beat", int'(out_data), 0);
		end else begin
			want = expected_beats.pop_front();
			check_field("char_out", int'(out_data[7:0]), int'(want.ch));
			check_field("source_index", int'(out_data[10:8]), int'(want.src));
			check_field("tdata padding", int'(out_data[15:11]), 0);
			check_field("char_valid", int'(out_user[0]), int'(want.valid));
			check_field("exhausted", int'(out_user[1]), int'(want.exh));
			check_field("overflow", int'(out_user[2]), int'(want.ovf));
			check_field("tlast", int'(out_last), int'(want.last));
		end
		beat_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_beat();
	end

	// The receiver stalls at random; no new stall begins during stretches with idling turned off.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			stall_left <= idle_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// After reset the string is empty: one empty permutation, then exhausted beats.
	task automatic test_empty_string();
		repeat (3) send_cmd(CMD_NEXT, 8'hff);
	endtask

	// Bytes on both sides of the sign boundary must sort as signed values.
	task automatic test_signed_order();
		send_cmd(CMD_CLEAR, 8'h00);
		send_cmd(CMD_APPEND, 8'h80);
		send_cmd(CMD_APPEND, 8'h7f);
		send_cmd(CMD_APPEND, 8'h00);
		send_cmd(CMD_APPEND, 8'hff);
		send_cmd(CMD_NEXT, 8'h00);
		send_cmd(CMD_NEXT, 8'h55);
	endtask

	// A full store with repeated bytes, then one append that is dropped and flagged.
	task automatic test_overflow();
		send_cmd(CMD_CLEAR, 8'haa);
		send_cmd(CMD_APPEND, 8'h41);
		send_cmd(CMD_APPEND, 8'h41);
		send_cmd(CMD_APPEND, 8'hc3);
		send_cmd(CMD_APPEND, 8'h10);
		send_cmd(CMD_APPEND, 8'h41);
		send_cmd(CMD_APPEND, 8'h7e);
		send_cmd(CMD_APPEND, 8'h81);
		send_cmd(CMD_APPEND, 8'h10);
		send_cmd(CMD_APPEND, 8'h55);
		send_cmd(CMD_NEXT, 8'h00);
		send_cmd(CMD_NEXT, 8'h00);
	endtask

	// One character has a single permutation; the unused command changes nothing.
	task automatic test_single_char();
		send_cmd(CMD_CLEAR, 8'h00);
		send_cmd(CMD_APPEND, 8'h33);
		send_cmd(CMD_UNUSED, 8'ha5);
		send_cmd(CMD_NEXT, 8'h00);
		send_cmd(CMD_NEXT, 8'h00);
	endtask

	// The sender holds off until the block has delivered everything it owes.
	task automatic test_pause_for_drain();
		send_cmd(CMD_CLEAR, 8'h00);
		repeat (3) send_cmd(CMD_APPEND, rand_char());
		send_cmd(CMD_NEXT, 8'h00);
		pause_until_drained();
		repeat (6) send_cmd(CMD_NEXT, rand_char());
		pause_until_drained();
	endtask

	// Mostly clear, appends and a run of requests; the rest is unframed noise.
	task automatic test_random_sequences();
		int sent, n, reqs, r;
		logic [CMD_W-1:0] cmd;
		sent = 0;
		while (sent < 60) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				send_cmd(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)));
				r = $urandom_range(0, 9);
				if (r < 6)
					n = $urandom_range(0, 3);
				else if (r < 9)
					n = $urandom_range(4, 6);
				else
					n = $urandom_range(7, 10);
				repeat (n) send_cmd(CMD_APPEND, rand_char());
				// Short strings are run through all their permutations, sometimes on to exhaustion.
				reqs = (n <= 3) ? perm_count(n) + $urandom_range(0, 2) : $urandom_range(1, 8);
				repeat (reqs) send_cmd(CMD_NEXT, CHAR_W'($urandom_range(0, 255)));
				sent += 1 + n + reqs;
				if ($urandom_range(0, 7) == 0)
					pause_until_drained();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					cmd = CMD_W'($urandom_range(0, 3));
					send_cmd(cmd, rand_char());
					if (cmd != CMD_UNUSED)
						sent++;
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_string();
		test_signed_order();
		test_overflow();
		test_single_char();
		test_pause_for_drain();
		test_random_sequences();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_beats.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0)
			report_mismatch("missing beats", expected_beats.size(), 0);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sspg_pkg.sv
rtl/core/sspg_dpath.sv
rtl/core/sspg_ctrl.sv
rtl/core/sorted_string_permutation_generator_unit.sv
tb/tb_sorted_string_permutation_generator_unit.sv
